// ===== hdl/nfa_pkg.sv =====
// Package for the neuron forward activation block.
// Holds widths, codes, the window job record and the back-end state type.
// No dependencies; every other file imports it.
package nfa_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS = 12;
    localparam int IN_W      = 16;
    localparam int Z_W       = 32;
    localparam int DER_W     = 13;
    localparam int ACC_W     = 48;
    localparam int CNT_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Default parameter values.
    localparam int MAX_WINDOW_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Shared divider widths.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 34;

    // Constants of the exponential.
    localparam logic [28:0] EXP_M1_Q30   = 29'd395007542;
    localparam int          TAYLOR_TERMS = 14;
    localparam int          EXP_IP_LIMIT = 32;

    // Layer modes.
    localparam logic [1:0] MODE_WSUM = 2'd0;
    localparam logic [1:0] MODE_MAX  = 2'd1;
    localparam logic [1:0] MODE_AVG  = 2'd2;

    // Activation kinds.
    localparam logic [1:0] ACT_SIGMOID = 2'd0;
    localparam logic [1:0] ACT_TANH    = 2'd1;
    localparam logic [1:0] ACT_RELU    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_KIND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 2'd2;

    // One finished window, handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]              mode;
        logic [1:0]              kind;
        logic signed [IN_W-1:0]  bias;
        logic signed [ACC_W-1:0] acc;
        logic signed [IN_W-1:0]  max;
        logic [CNT_W-1:0]        count;
    } job_t;

    // Back-end sequencer states.
    typedef enum logic [4:0] {
        B_IDLE,
        B_ZCALC,
        B_ZDIV,
        B_ZSAT,
        B_ACTSEL,
        B_EXP_MUL,
        B_EXP_RCP,
        B_EXP_ACC,
        B_EXP_IP,
        B_ACT,
        B_SIG_W,
        B_SIG_DER,
        B_TQ_W,
        B_TT,
        B_TT_W,
        B_TDER_MUL,
        B_TDER_FIN,
        B_OUT
    } back_state_t;

endpackage

// ===== hdl/nfa_in_if.sv =====
// Input channel of the neuron forward activation block.
// Valid/ready handshake with one input word; depends on nfa_pkg.
interface nfa_in_if import nfa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] activation_in;
    logic signed [IN_W-1:0] weight_in;
    logic                   last;

    modport source (output valid, activation_in, weight_in, last, input ready);
    modport sink (input valid, activation_in, weight_in, last, output ready);
endinterface

// ===== hdl/nfa_out_if.sv =====
// Result channel of the neuron forward activation block.
// Valid/ready handshake with one result word; depends on nfa_pkg.
interface nfa_out_if import nfa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [Z_W-1:0]  z_value;
    logic signed [IN_W-1:0] activation_out;
    logic [DER_W-1:0]       derivative_out;

    modport source (output valid, z_value, activation_out, derivative_out, input ready);
    modport sink (input valid, z_value, activation_out, derivative_out, output ready);
endinterface

// ===== hdl/nfa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the back end for averages and activations; uses nfa_pkg.
module nfa_div import nfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);
    localparam int CW = $clog2(DIV_NUM_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    // One shift-and-subtract step per cycle while busy.
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            rem_next = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== hdl/nfa_queue.sv =====
// Short job queue between the front end and the back end.
// Holds finished window records; uses job_t from nfa_pkg.
module nfa_queue import nfa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  job_t                       push_job,
    input  logic                       pop,
    output logic                       q_valid,
    output job_t                       q_job,
    output logic [$clog2(DEPTH+1)-1:0] q_cnt
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW-1:0] cnt_reg, cnt_next;
    logic          do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign q_valid = cnt_reg != '0;
    assign q_job   = mem[rd_ptr_reg];
    assign q_cnt   = cnt_reg;

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (cnt_reg == QW'(DEPTH)) && !do_pop))
        else $error("job pushed into a full queue");

    // The fill count never exceeds the depth.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QW'(DEPTH))
        else $error("queue fill count out of range");

    // Taking the only job without a new one empties the queue.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !push && (cnt_reg == QW'(1))) |=> !q_valid)
        else $error("queue not empty after last job taken");
endmodule

// ===== hdl/nfa_front.sv =====
// Front end: accepts input words, keeps the window sums, maximum and count.
// Pushes one job per window into the queue; uses nfa_pkg and nfa_in_if.
module nfa_front import nfa_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    nfa_in_if.sink                           in_ch,
    input  logic [1:0]                       layer_mode,
    input  logic [1:0]                       activation_kind,
    input  logic signed [IN_W-1:0]           bias,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_cnt,
    output logic                             push,
    output job_t                             push_job
);
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // Stage one: product of the accepted word.
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic [1:0]               s1_mode_reg;
    logic signed [IN_W-1:0]   s1_x_reg;
    logic signed [2*IN_W-1:0] s1_prod_reg;

    // Window state.
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [IN_W-1:0]   max_reg, max_next;
    logic [CW-1:0]            cnt_reg, cnt_next;

    logic                     accept;
    logic [QCW:0]             used;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  acc_upd;
    logic signed [IN_W-1:0]   max_upd;
    logic [CW-1:0]            cnt_upd;

    // Room is kept for a window that is about to close in stage one.
    assign used        = {1'b0, q_cnt} + {{QCW{1'b0}}, s1_valid_reg & s1_last_reg};
    assign in_ch.ready = used < (QCW+1)'(QUEUE_DEPTH);
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= in_ch.last;
            s1_mode_reg <= layer_mode;
            s1_x_reg    <= in_ch.activation_in;
            s1_prod_reg <= in_ch.activation_in * in_ch.weight_in;
        end
    end

    // Stage two: saturating accumulate, running maximum, saturating count.
    always_comb
    begin
        if (s1_mode_reg == MODE_AVG)
        begin
            addend = ACC_W'(s1_x_reg);
        end
        else if (s1_mode_reg == MODE_MAX)
        begin
            addend = '0;
        end
        else
        begin
            addend = ACC_W'(s1_prod_reg);
        end
        sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(addend);
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            acc_upd = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_upd = sum[ACC_W-1:0];
        end
        max_upd = (s1_x_reg > max_reg) ? s1_x_reg : max_reg;
        cnt_upd = (cnt_reg < CW'(MAX_WINDOW)) ? cnt_reg + 1'b1 : cnt_reg;

        acc_next = acc_reg;
        max_next = max_reg;
        cnt_next = cnt_reg;
        push     = 1'b0;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                push     = 1'b1;
                acc_next = '0;
                max_next = {1'b1, {(IN_W-1){1'b0}}};
                cnt_next = '0;
            end
            else
            begin
                acc_next = acc_upd;
                max_next = max_upd;
                cnt_next = cnt_upd;
            end
        end
        push_job.mode  = s1_mode_reg;
        push_job.kind  = activation_kind;
        push_job.bias  = bias;
        push_job.acc   = acc_upd;
        push_job.max   = max_upd;
        push_job.count = CNT_W'(cnt_upd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            max_reg <= {1'b1, {(IN_W-1){1'b0}}};
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            max_reg <= max_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== hdl/nfa_back.sv =====
// Back end: forms z, the exponential, the activation and its derivative.
// One job at a time through a sequencer and a shared divider; uses nfa_pkg, nfa_div.
module nfa_back import nfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  job_t    q_job,
    output logic    pop,
    nfa_out_if.source out_ch
);
    localparam logic [30:0] Q30 = 31'h4000_0000;

    back_state_t state_reg, state_next;

    job_t                   job_reg, job_next;
    logic signed [ACC_W:0]  zw_reg, zw_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [4:0]             ip_reg, ip_next;
    logic [29:0]            f_reg, f_next;
    logic [30:0]            term_reg, term_next;
    logic signed [32:0]     sum_reg, sum_next;
    logic [3:0]             n_reg, n_next;
    logic [61:0]            prod_reg, prod_next;
    logic [63:0]            rcp_reg, rcp_next;
    logic [30:0]            e_reg, e_next;
    logic [30:0]            q_reg, q_next;
    logic signed [IN_W-1:0] act_reg, act_next;
    logic [DER_W-1:0]       der_reg, der_next;

    logic                   out_valid_reg, out_valid_next;
    logic signed [Z_W-1:0]  out_z_reg;
    logic signed [IN_W-1:0] out_act_reg;
    logic [DER_W-1:0]       out_der_reg;
    logic                   load;

    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quo;

    logic [ACC_W-1:0]       acc_mag;
    logic signed [ACC_W:0]  zb;
    logic signed [32:0]     zx;
    logic [32:0]            mag;
    logic [33:0]            xarg;
    logic [31:0]            den;
    logic [60:0]            ipm;
    logic [25:0]            sder;
    logic [30:0]            tnum;
    logic [29:0]            term_div;

    // Reciprocals ceil(2^34 / n) for the series divisors two to fourteen. For a
    // dividend below 2^30 the product shifted right by 34 is the exact quotient.
    function automatic logic [33:0] recip_m(input logic [3:0] d);
        logic [33:0] m;
        case (d)
            4'd2:    m = 34'd8589934592;
            4'd3:    m = 34'd5726623062;
            4'd4:    m = 34'd4294967296;
            4'd5:    m = 34'd3435973837;
            4'd6:    m = 34'd2863311531;
            4'd7:    m = 34'd2454267027;
            4'd8:    m = 34'd2147483648;
            4'd9:    m = 34'd1908874354;
            4'd10:   m = 34'd1717986919;
            4'd11:   m = 34'd1561806290;
            4'd12:   m = 34'd1431655766;
            4'd13:   m = 34'd1321528399;
            4'd14:   m = 34'd1227133514;
            default: m = '0;
        endcase
        return m;
    endfunction

    nfa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        zw_next    = zw_reg;
        z_next     = z_reg;
        ip_next    = ip_reg;
        f_next     = f_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        prod_next  = prod_reg;
        rcp_next   = rcp_reg;
        e_next     = e_reg;
        q_next     = q_reg;
        act_next   = act_reg;
        der_next   = der_reg;
        pop        = 1'b0;
        load       = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = DIV_DEN_W'(1);

        acc_mag = job_reg.acc[ACC_W-1] ? ACC_W'(-job_reg.acc) : ACC_W'(job_reg.acc);
        zb      = zw_reg + ((job_reg.mode != MODE_MAX && job_reg.mode != MODE_AVG)
                            ? (ACC_W+1)'(job_reg.bias) : '0);
        zx      = 33'(z_reg);
        mag     = zx[32] ? 33'(-zx) : 33'(zx);
        xarg    = (job_reg.kind == ACT_TANH) ? {mag, 1'b0} : {1'b0, mag};
        den     = 32'(Q30) + 32'(e_reg);
        ipm     = 61'(e_reg) * 61'(EXP_M1_Q30) + 61'(Q30 >> 1);
        sder    = 26'(act_reg[12:0]) * 26'(13'(1 << FRAC_BITS) - act_reg[12:0])
                  + 26'(1 << (FRAC_BITS - 1));
        tnum    = Q30 - q_reg;
        // Division by one is the shifted product itself.
        term_div = (n_reg == 4'd1) ? prod_reg[59:30] : rcp_reg[63:34];

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    job_next   = q_job;
                    state_next = B_ZCALC;
                end
            end
            // Pre-activation per layer mode; the average goes through the divider.
            B_ZCALC:
            begin
                if (job_reg.mode == MODE_MAX)
                begin
                    zw_next    = (ACC_W+1)'(job_reg.max);
                    state_next = B_ZSAT;
                end
                else if (job_reg.mode == MODE_AVG)
                begin
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(acc_mag) + DIV_NUM_W'(job_reg.count >> 1);
                    div_den    = DIV_DEN_W'(job_reg.count);
                    state_next = B_ZDIV;
                end
                else
                begin
                    zw_next    = ((ACC_W+1)'(job_reg.acc) + (ACC_W+1)'(1 << (FRAC_BITS - 1)))
                                 >>> FRAC_BITS;
                    state_next = B_ZSAT;
                end
            end
            B_ZDIV:
            begin
                if (div_done)
                begin
                    zw_next    = job_reg.acc[ACC_W-1] ? -(ACC_W+1)'(div_quo[ACC_W-1:0])
                                                      : (ACC_W+1)'(div_quo[ACC_W-1:0]);
                    state_next = B_ZSAT;
                end
            end
            // Bias in every mode but max and average, then saturation to 32 bits.
            B_ZSAT:
            begin
                if (zb > (ACC_W+1)'(2147483647))
                begin
                    z_next = 32'sh7FFF_FFFF;
                end
                else if (zb < -(ACC_W+1)'(64'sd2147483648))
                begin
                    z_next = 32'sh8000_0000;
                end
                else
                begin
                    z_next = zb[Z_W-1:0];
                end
                state_next = B_ACTSEL;
            end
            // Choose the activation; set up the exponential of the magnitude.
            B_ACTSEL:
            begin
                if (job_reg.kind == ACT_RELU)
                begin
                    if (z_reg < 0)
                    begin
                        act_next = '0;
                    end
                    else if (z_reg > 32'sd32767)
                    begin
                        act_next = 16'sd32767;
                    end
                    else
                    begin
                        act_next = z_reg[IN_W-1:0];
                    end
                    der_next   = (z_reg > 0) ? DER_W'(1 << FRAC_BITS) : '0;
                    state_next = B_OUT;
                end
                else if (job_reg.kind == ACT_SIGMOID || job_reg.kind == ACT_TANH)
                begin
                    if (xarg[33:FRAC_BITS] >= (34 - FRAC_BITS)'(EXP_IP_LIMIT))
                    begin
                        e_next     = '0;
                        state_next = B_ACT;
                    end
                    else
                    begin
                        ip_next    = xarg[FRAC_BITS+4:FRAC_BITS];
                        f_next     = {xarg[FRAC_BITS-1:0], (30 - FRAC_BITS)'(0)};
                        term_next  = Q30;
                        sum_next   = 33'(Q30);
                        n_next     = 4'd1;
                        state_next = B_EXP_MUL;
                    end
                end
                else
                begin
                    act_next   = '0;
                    der_next   = '0;
                    state_next = B_OUT;
                end
            end
            // Series for the fraction: multiply, divide by n through its reciprocal, add.
            B_EXP_MUL:
            begin
                prod_next  = 62'(term_reg) * 62'(f_reg);
                state_next = B_EXP_RCP;
            end
            B_EXP_RCP:
            begin
                rcp_next   = prod_reg[59:30] * recip_m(n_reg);
                state_next = B_EXP_ACC;
            end
            B_EXP_ACC:
            begin
                term_next = 31'(term_div);
                if (n_reg[0])
                begin
                    sum_next = sum_reg - 33'(term_div);
                end
                else
                begin
                    sum_next = sum_reg + 33'(term_div);
                end
                if (n_reg == 4'(TAYLOR_TERMS))
                begin
                    e_next     = sum_next[30:0];
                    state_next = B_EXP_IP;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = B_EXP_MUL;
                end
            end
            // Integer part: one multiply by e^-1 per unit.
            B_EXP_IP:
            begin
                if (ip_reg == '0)
                begin
                    state_next = B_ACT;
                end
                else
                begin
                    e_next     = ipm[60:30];
                    ip_next    = ip_reg - 1'b1;
                    state_next = B_EXP_IP;
                end
            end
            B_ACT:
            begin
                div_start = 1'b1;
                if (job_reg.kind == ACT_TANH)
                begin
                    div_num    = {3'b0, e_reg, 30'b0} + DIV_NUM_W'(den >> 1);
                    div_den    = DIV_DEN_W'(den);
                    state_next = B_TQ_W;
                end
                else
                begin
                    div_num    = ((z_reg < 0) ? DIV_NUM_W'(e_reg) : DIV_NUM_W'(Q30))
                                 * DIV_NUM_W'(2 << FRAC_BITS) + DIV_NUM_W'(den);
                    div_den    = {1'b0, den, 1'b0};
                    state_next = B_SIG_W;
                end
            end
            B_SIG_W:
            begin
                if (div_done)
                begin
                    act_next   = div_quo[IN_W-1:0];
                    state_next = B_SIG_DER;
                end
            end
            B_SIG_DER:
            begin
                der_next   = sder[FRAC_BITS+DER_W-1:FRAC_BITS];
                state_next = B_OUT;
            end
            B_TQ_W:
            begin
                if (div_done)
                begin
                    q_next     = div_quo[30:0];
                    state_next = B_TT;
                end
            end
            B_TT:
            begin
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'(Q30 - e_reg) * DIV_NUM_W'(2 << FRAC_BITS)
                             + DIV_NUM_W'(den);
                div_den    = {1'b0, den, 1'b0};
                state_next = B_TT_W;
            end
            B_TT_W:
            begin
                if (div_done)
                begin
                    act_next   = (z_reg < 0) ? -div_quo[IN_W-1:0] : div_quo[IN_W-1:0];
                    state_next = B_TDER_MUL;
                end
            end
            B_TDER_MUL:
            begin
                prod_next  = 62'(q_reg) * 62'(tnum);
                state_next = B_TDER_FIN;
            end
            B_TDER_FIN:
            begin
                der_next   = DER_W'((prod_reg + (62'(1) << (57 - FRAC_BITS)))
                                    >> (58 - FRAC_BITS));
                state_next = B_OUT;
            end
            // Hand the result word to the output register.
            B_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ch.ready) || load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        zw_reg   <= zw_next;
        z_reg    <= z_next;
        ip_reg   <= ip_next;
        f_reg    <= f_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
        rcp_reg  <= rcp_next;
        e_reg    <= e_next;
        q_reg    <= q_next;
        act_reg  <= act_next;
        der_reg  <= der_next;
        if (load)
        begin
            out_z_reg   <= z_reg;
            out_act_reg <= act_reg;
            out_der_reg <= der_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.z_value        = out_z_reg;
    assign out_ch.activation_out = out_act_reg;
    assign out_ch.derivative_out = out_der_reg;
endmodule

// ===== hdl/neuron_forward_activation.sv =====
// Neuron forward pass: accumulate a window of words, then z, activation and derivative.
// The front end takes one input word per clock while its job queue has room; the word
// marked last closes the window and queues it. The back end turns each window into one
// result word through a sequencer, a reciprocal multiply for the series terms and a
// shared one-bit-per-cycle 64-bit divider. An average adds one division; sigmoid sums
// fourteen series terms, multiplies once by e^-1 per unit of the integer part of the
// exponent up to 31 and makes one division, and tanh does the same with two divisions;
// an argument of 32 or more skips the series and the integer part.
// Configuration writes are taken at any edge with cfg_we high; there is no clearing pass.
module neuron_forward_activation import nfa_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    nfa_in_if.sink               in_ch,
    nfa_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    logic [1:0]             layer_mode_reg;
    logic [1:0]             activation_kind_reg;
    logic signed [IN_W-1:0] bias_reg;

    logic                             push;
    job_t                             push_job;
    logic                             pop;
    logic                             q_valid;
    job_t                             q_job;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_cnt;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_mode_reg      <= MODE_WSUM;
            activation_kind_reg <= ACT_SIGMOID;
            bias_reg            <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAYER_MODE: layer_mode_reg      <= cfg_data[1:0];
                CFG_ACT_KIND:   activation_kind_reg <= cfg_data[1:0];
                CFG_BIAS:       bias_reg            <= cfg_data;
                default:        ;
            endcase
        end
    end

    nfa_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .layer_mode      (layer_mode_reg),
        .activation_kind (activation_kind_reg),
        .bias            (bias_reg),
        .q_cnt           (q_cnt),
        .push            (push),
        .push_job        (push_job)
    );

    nfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_cnt    (q_cnt)
    );

    nfa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .out_ch  (out_ch)
    );
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for neuron_forward_activation: streams windows of words, predicts z,
// activation and derivative in a scoreboard class, and checks every result word.
// Depends on nfa_pkg, nfa_in_if, nfa_out_if and the block itself.
module tb;
    import nfa_pkg::*;

    localparam int  HALF_PERIOD   = 6;
    localparam int  WINDOW_LIMIT  = 4096;
    localparam int  SETTLE_CYCLES = 1300;
    localparam int  RANDOM_ITEMS  = 1500;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint ACC_HI = (longint'(1) << 47) - 1;
    localparam longint ACC_LO = -(longint'(1) << 47);
    localparam longint Q30 = longint'(1) << 30;
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [Z_W-1:0]  z;
        logic signed [IN_W-1:0] act;
        logic [DER_W-1:0]       der;
    } neuron_result_t;

    // Mirror of the block: window state, configuration and the results it owes.
    class window_scoreboard;
        logic [1:0]          mode;
        logic [1:0]          kind;
        longint              bias_q;
        longint              acc;
        longint              peak;
        int                  count;
        neuron_result_t      owed[$];
        int                  errors;

        function new();
            mode = MODE_WSUM;
            kind = ACT_SIGMOID;
            bias_q = 0;
            acc = 0;
            peak = -32768;
            count = 0;
            errors = 0;
        endfunction

        function void configure(logic [1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_LAYER_MODE) mode = val[1:0];
            else if (idx == CFG_ACT_KIND) kind = val[1:0];
            else if (idx == CFG_BIAS) bias_q = longint'($signed(val));
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // e^-x in Q2.30 for a nonnegative x with FRAC_BITS fractional bits.
        function longint unsigned exp_neg_q30(longint unsigned x);
            longint unsigned ip;
            longint unsigned f;
            longint unsigned term;
            longint          sum;
            longint unsigned r;
            ip = x >> FRAC_BITS;
            f = (x & (ONE - 1)) << (30 - FRAC_BITS);
            sum = Q30;
            term = Q30;
            if (ip >= 32) return 0;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * f) >> 30) / n;
                if (n % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            r = longint'(sum);
            for (longint unsigned n = 0; n < ip; n++)
                r = (r * 64'd395007542 + (Q30 >> 1)) >> 30;
            return r;
        endfunction

        // Update the window with one accepted word; a word marked last owes a result.
        function void note_word(logic signed [IN_W-1:0] x_in, logic signed [IN_W-1:0] w_in,
                                logic last_in);
            longint          x;
            longint          w;
            longint          zv;
            longint          act;
            longint          der;
            longint unsigned mag;
            longint unsigned a;
            longint unsigned q;
            longint unsigned e;
            longint unsigned den;
            longint unsigned num;
            longint unsigned p;
            longint unsigned t;
            neuron_result_t  res;
            x = x_in;
            w = w_in;
            act = 0;
            der = 0;
            if (mode == MODE_AVG) acc = acc + x;
            else if (mode != MODE_MAX) acc = acc + x * w;
            if (acc > ACC_HI) acc = ACC_HI;
            if (acc < ACC_LO) acc = ACC_LO;
            if (x > peak) peak = x;
            if (count < WINDOW_LIMIT) count++;
            if (!last_in) return;

            // Pre-activation for the mode in force on the last word.
            if (mode == MODE_MAX) begin
                zv = peak;
            end
            else if (mode == MODE_AVG) begin
                a = acc < 0 ? -acc : acc;
                q = (a + count / 2) / count;
                zv = acc < 0 ? -longint'(q) : longint'(q);
            end
            else begin
                zv = ((acc + (ONE >> 1)) >>> FRAC_BITS) + bias_q;
            end
            if (zv > 64'sd2147483647) zv = 64'sd2147483647;
            if (zv < -64'sd2147483648) zv = -64'sd2147483648;
            mag = zv < 0 ? -zv : zv;

            if (kind == ACT_SIGMOID) begin
                e = exp_neg_q30(mag);
                den = Q30 + e;
                num = zv >= 0 ? Q30 : e;
                act = longint'((num * (2 * ONE) + den) / (2 * den));
                der = (act * (ONE - act) + (ONE >> 1)) >>> FRAC_BITS;
            end
            else if (kind == ACT_TANH) begin
                e = exp_neg_q30(2 * mag);
                den = Q30 + e;
                q = ((e << 30) + den / 2) / den;
                p = Q30 - q;
                t = ((Q30 - e) * (2 * ONE) + den) / (2 * den);
                act = zv < 0 ? -longint'(t) : longint'(t);
                der = longint'((q * p + (longint'(1) << (57 - FRAC_BITS))) >> (58 - FRAC_BITS));
            end
            else if (kind == ACT_RELU) begin
                act = zv < 0 ? 0 : (zv > 32767 ? 32767 : zv);
                der = zv > 0 ? ONE : 0;
            end

            acc = 0;
            peak = -32768;
            count = 0;
            res.z = zv[Z_W-1:0];
            res.act = act[IN_W-1:0];
            res.der = der[DER_W-1:0];
            owed = {owed, res};
        endfunction

        // Compare one result word against the oldest owed result.
        function void check_result(neuron_result_t got);
            neuron_result_t exp_r;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result word z=%0d act=%0d der=%0d",
                         $time, got.z, got.act, got.der);
                errors++;
                return;
            end
            exp_r = owed.pop_front();
            if (got.z !== exp_r.z) begin
                $display("%0t: z_value expected %0d actual %0d", $time, exp_r.z, got.z);
                errors++;
            end
            if (got.act !== exp_r.act) begin
                $display("%0t: activation_out expected %0d actual %0d",
                         $time, exp_r.act, got.act);
                errors++;
            end
            if (got.der !== exp_r.der) begin
                $display("%0t: derivative_out expected %0d actual %0d",
                         $time, exp_r.der, got.der);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    longint               cycles = 0;
    int                   long_hold;
    bit                   no_idle;
    window_scoreboard     sb;

    nfa_in_if  in_ch();
    nfa_out_if out_ch();

    neuron_forward_activation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    always #HALF_PERIOD clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold, then take one word.
    initial
    begin
        int stall;
        bit held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold > 0 && !held)
            begin
                stall = long_hold;
                held = 1'b1;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            sb.check_result({out_ch.z_value, out_ch.activation_out, out_ch.derivative_out});
        end
    end

    // Drive one input word after a random gap and wait until it is taken.
    task automatic send_word(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] w,
                             logic l);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.activation_in <= x;
        in_ch.weight_in <= w;
        in_ch.last <= l;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_word(x, w, l);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers while the block is idle; index 3 is not a register.
    task automatic set_config(logic [1:0] m, logic [1:0] k, logic [CFG_W-1:0] b);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_LAYER_MODE;
        cfg_data <= {14'($urandom), m};
        @(posedge clk);
        sb.configure(CFG_LAYER_MODE, cfg_data);
        cfg_index <= CFG_ACT_KIND;
        cfg_data <= {14'($urandom), k};
        @(posedge clk);
        sb.configure(CFG_ACT_KIND, cfg_data);
        cfg_index <= CFG_BIAS;
        cfg_data <= b;
        @(posedge clk);
        sb.configure(CFG_BIAS, cfg_data);
        cfg_index <= CFG_UNUSED;
        cfg_data <= CFG_W'($urandom);
        @(posedge clk);
        sb.configure(CFG_UNUSED, cfg_data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mix of extremes, small values that keep z in the curved region, and full range.
    function automatic logic signed [IN_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3, 4: return IN_W'($signed($urandom_range(0, 16384)) - 8192);
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic send_window(int len);
        for (int i = 0; i < len; i++)
            send_word(pick_value(), pick_value(), i == len - 1);
    endtask

    initial
    begin
        int sent;
        int len;
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LAYER_MODE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.activation_in = '0;
        in_ch.weight_in = '0;
        in_ch.last = 1'b0;
        long_hold = 0;
        no_idle = 1'b0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: weighted sums at the extremes with sigmoid and tanh.
        set_config(MODE_WSUM, ACT_SIGMOID, 16'd0);
        send_word(16'sd0, 16'sd0, 1'b1);
        send_word(16'sd32767, 16'sd32767, 1'b1);
        send_word(-16'sd32768, 16'sd32767, 1'b1);
        send_word(16'sd2048, 16'sd4096, 1'b1);
        set_config(MODE_WSUM, ACT_TANH, 16'h7FFF);
        send_word(-16'sd32768, -16'sd32768, 1'b1);
        send_word(16'sd0, 16'sd0, 1'b1);
        set_config(MODE_WSUM, ACT_TANH, 16'h8000);
        send_word(16'sd100, 16'sd0, 1'b1);
        // Max pooling with relu, including an all-most-negative window.
        set_config(MODE_MAX, ACT_RELU, 16'h1234);
        send_word(-16'sd32768, 16'sd5, 1'b0);
        send_word(-16'sd32768, 16'sd5, 1'b1);
        send_word(16'sd32767, 16'sd0, 1'b0);
        send_word(16'sd3, 16'sd0, 1'b1);
        // Average pooling where the quotient lands on a half, both signs.
        set_config(MODE_AVG, ACT_SIGMOID, 16'd0);
        send_word(16'sd1, 16'sd0, 1'b0);
        send_word(16'sd2, 16'sd0, 1'b1);
        send_word(-16'sd1, 16'sd0, 1'b0);
        send_word(-16'sd2, 16'sd0, 1'b1);
        // The unused activation kind and the unused layer mode.
        set_config(CFG_UNUSED, CFG_UNUSED, 16'd77);
        send_word(16'sd4096, 16'sd4096, 1'b1);
        set_config(CFG_UNUSED, ACT_RELU, 16'd0);
        send_word(16'sd4096, 16'sd8192, 1'b1);
        // Mode change inside a window.
        set_config(MODE_WSUM, ACT_RELU, 16'd0);
        send_word(16'sd4096, 16'sd4096, 1'b0);
        send_word(16'sd8192, 16'sd4096, 1'b0);
        set_config(MODE_AVG, ACT_TANH, 16'd0);
        send_word(16'sd12, 16'sd4096, 1'b1);

        // Random windows, with the configuration changed between phases.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_config(2'(phase % 4), 2'((phase + phase / 4) % 4),
                       phase == 1 ? 16'h8000 : (phase == 2 ? 16'h7FFF : CFG_W'($urandom)));
            no_idle = (phase % 3 == 2);
            if (phase == 3) long_hold = 400;
            for (int n = 0; n < 130; n += len)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
                send_window(len);
                sent += len;
                if (phase == 5 && n == 0) drain();
            end
            phase++;
        end
        no_idle = 1'b1;

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
